FILE: rtl/tsg_pkg.sv
`default_nettype none

package tsg_pkg;

    localparam int TAPS            = 101;
    localparam int CUTOFF_HZ       = 30;
    localparam int SAMPLE_RATE_HZ  = 48000;
    localparam int SINE_TABLE_BITS = 10;

    localparam int SAMPLE_W   = 24;
    localparam int DEPTH_W    = 17;
    localparam int PSTEP_W    = 20;
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 18;
    localparam int COEF_W     = 18;
    localparam int GAIN_FRAC  = 17;
    localparam int S17_W      = GAIN_W + 1;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam int TAP_IDX_W = $clog2(TAPS);
    localparam int QTR_BITS  = SINE_TABLE_BITS - 2;
    localparam int QTR_N     = 1 << QTR_BITS;

    localparam int ACC_W     = COEF_W + GAIN_W + 1 + TAP_IDX_W;
    localparam int FG_W      = ACC_W - GAIN_FRAC;
    localparam int MUL_A_W   = FG_W;
    localparam int MUL_B_W   = SAMPLE_W + 1;
    localparam int MUL_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = CFG_ADDR_W'(1);

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(32768);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL  = DEPTH_W'(65536);
    localparam logic [PSTEP_W-1:0] PSTEP_RESET = PSTEP_W'(447392);
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = GAIN_W'(131072);

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF    = 64'd536870912;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned INV_PI_Q30  = 64'd341782638;
    localparam longint          WIN_A_Q30   = 64'sd579820585;
    localparam longint          WIN_B_Q30   = 64'sd493921239;
    localparam longint          Q30_HALF_S  = 64'sd536870912;

    localparam int TAP_M = TAPS - 1;
    localparam int TAP_C = TAP_M / 2;

    // quarter-wave sine magnitude, q30, for g in [0, 2^30]
    function automatic longint unsigned sine_mag_q30(input longint unsigned g);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (g * HALF_PI_Q30 + Q30_HALF) >> 30;
        x2 = (x * x + Q30_HALF) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / 110);
        t  = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / 72);
        t  = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / 42);
        t  = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / 20);
        t  = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / 6);
        s  = (x * t + Q30_HALF) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return s;
    endfunction

    function automatic longint sine_q30(input logic [31:0] ph);
        longint unsigned g;
        longint unsigned s;
        g = {34'd0, ph[29:0]};
        if (ph[30])
        begin
            g = Q30_ONE - g;
        end
        s = sine_mag_q30(g);
        return ph[31] ? -longint'(s) : longint'(s);
    endfunction

    // shift-subtract division, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | {63'd0, n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [COEF_W-1:0] make_weight(input int i);
        longint unsigned sinc_mag;
        longint unsigned d;
        longint unsigned r;
        longint unsigned sm;
        longint unsigned mag;
        logic [31:0]     p;
        logic [31:0]     wq;
        longint          s;
        longint          w;
        logic            neg;
        logic signed [COEF_W-1:0] m;
        neg = 1'b0;
        if (i == TAP_C)
        begin
            sinc_mag = ((64'd2 * CUTOFF_HZ << 30) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
        end
        else
        begin
            d   = (i > TAP_C) ? 64'(i - TAP_C) : 64'(TAP_C - i);
            r   = (64'(CUTOFF_HZ) * d) % SAMPLE_RATE_HZ;
            p   = 32'(((r << 32) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ);
            s   = sine_q30(p);
            neg = s < 0;
            sm  = neg ? 64'(-s) : 64'(s);
            sinc_mag = (udiv64(sm * INV_PI_Q30, d) + Q30_HALF) >> 30;
        end
        wq = 32'(((64'(i) << 32) + TAP_M / 2) / TAP_M);
        w  = WIN_A_Q30 - ((WIN_B_Q30 * sine_q30(wq + 32'h4000_0000) + Q30_HALF_S) >>> 30);
        if (w < 0)
        begin
            w = 0;
        end
        mag = (sinc_mag * 64'(w) + (64'd1 << 42)) >> 43;
        m   = COEF_W'(mag);
        return neg ? -m : m;
    endfunction

    typedef logic signed [COEF_W-1:0] coef_rom_t [TAPS];
    typedef logic [GAIN_W-1:0]        sine_rom_t [QTR_N];

    function automatic coef_rom_t build_coefs();
        coef_rom_t c;
        for (int i = 0; i < TAPS; i++)
        begin
            c[i] = make_weight(i);
        end
        return c;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t       t;
        longint unsigned s;
        for (int j = 0; j < QTR_N; j++)
        begin
            s    = sine_mag_q30(64'(j) << (32 - SINE_TABLE_BITS));
            t[j] = GAIN_W'((s + 64'd4096) >> 13);
        end
        return t;
    endfunction

    localparam coef_rom_t TAP_WEIGHTS = build_coefs();
    localparam sine_rom_t SINE_QTR    = build_sine();
    localparam logic [GAIN_W-1:0] SINE_PEAK = GAIN_W'((sine_mag_q30(Q30_ONE) + 64'd4096) >> 13);

    // microcode
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t ST_IDLE   = PC_W'(0);
    localparam pc_t ST_LFO    = PC_W'(1);
    localparam pc_t ST_GAIN   = PC_W'(2);
    localparam pc_t ST_HIST   = PC_W'(3);
    localparam pc_t ST_TAP    = PC_W'(4);
    localparam pc_t ST_DRAIN  = PC_W'(5);
    localparam pc_t ST_SETTLE = PC_W'(6);
    localparam pc_t ST_FG     = PC_W'(7);
    localparam pc_t ST_MUL_L  = PC_W'(8);
    localparam pc_t ST_MUL_R  = PC_W'(9);
    localparam pc_t ST_OUT    = PC_W'(10);

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_GAIN  = 3'd1,
        MUL_TAP   = 3'd2,
        MUL_LEFT  = 3'd3,
        MUL_RIGHT = 3'd4
    } mul_sel_t;

    typedef enum logic [2:0] {
        BR_NEXT     = 3'd0,
        BR_JUMP     = 3'd1,
        BR_WAIT_IN  = 3'd2,
        BR_LOOP     = 3'd3,
        BR_WAIT_OUT = 3'd4
    } br_t;

    typedef struct packed {
        logic     accept;
        logic     lfo;
        mul_sel_t mul_sel;
        logic     hist_wr;
        logic     tap_issue;
        logic     fg_ld;
        logic     left_ld;
        logic     out_ld;
        br_t      br;
        pc_t      target;
    } ctrl_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t c;
        c = '{accept: 1'b0, lfo: 1'b0, mul_sel: MUL_NONE, hist_wr: 1'b0,
              tap_issue: 1'b0, fg_ld: 1'b0, left_ld: 1'b0, out_ld: 1'b0,
              br: BR_NEXT, target: ST_IDLE};
        case (pc)
            ST_IDLE:
            begin
                c.accept = 1'b1;
                c.br     = BR_WAIT_IN;
            end
            ST_LFO:    c.lfo = 1'b1;
            ST_GAIN:   c.mul_sel = MUL_GAIN;
            ST_HIST:   c.hist_wr = 1'b1;
            ST_TAP:
            begin
                c.tap_issue = 1'b1;
                c.mul_sel   = MUL_TAP;
                c.br        = BR_LOOP;
                c.target    = ST_TAP;
            end
            ST_DRAIN:  c.mul_sel = MUL_TAP;
            ST_SETTLE: c.br = BR_NEXT;
            ST_FG:     c.fg_ld = 1'b1;
            ST_MUL_L:  c.mul_sel = MUL_LEFT;
            ST_MUL_R:
            begin
                c.mul_sel = MUL_RIGHT;
                c.left_ld = 1'b1;
            end
            ST_OUT:
            begin
                c.out_ld = 1'b1;
                c.br     = BR_WAIT_OUT;
                c.target = ST_IDLE;
            end
            default:
            begin
                c.br     = BR_JUMP;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tsg_ifs.sv
`default_nettype none

interface tsg_in_if;
    import tsg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface tsg_out_if;
    import tsg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface tsg_cfg_if;
    import tsg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tremolo_sine_lfo_smoothed_gain_unit.sv
// channel     dir   payload                         handshake
// sample_in   in    left_in, right_in (s24)         valid / ready
// sample_out  out   left_out, right_out (s24)       valid / ready
// cfg         in    addr (2b), data (20b)           valid / ready, always ready
//
// one item walks idle (the step that accepts it), lfo, gain, hist, the tap loop, drain,
// settle, fg, mul_l, mul_r and out; its result turns valid when the out step loads it
// the filter loop walks one tap per cycle through the single shared multiplier
// a finished item sits in the output register while the next item is taken
// async reset clears phase, history valid bits, sequencer and output valid
// a stalled output holds the sequencer in its last step

`default_nettype none

module tremolo_sine_lfo_smoothed_gain_unit (
    input  logic         clk,
    input  logic         rst_n,
    tsg_cfg_if.sink      cfg,
    tsg_in_if.sink       sample_in,
    tsg_out_if.source    sample_out
);
    import tsg_pkg::*;

    localparam logic signed [MUL_W-1:0]    MUL_HALF   = MUL_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [ACC_W-1:0]    ACC_HALF   = ACC_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [MUL_W-1:0]    SAT_MAX    = MUL_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [MUL_W-1:0]    SAT_MIN    = -SAT_MAX - 1;
    localparam logic signed [GAIN_W+1:0]   GAIN_ONE_S = (GAIN_W + 2)'(GAIN_ONE);
    localparam logic [TAP_IDX_W-1:0]       TAP_LAST   = TAP_IDX_W'(TAPS - 1);

    // sequencer
    pc_t   pc_reg;
    pc_t   pc_next;
    ctrl_t uc;
    logic  in_fire;
    logic  out_free;
    logic  tap_last;

    // config
    logic [DEPTH_W-1:0] depth_reg;
    logic [PSTEP_W-1:0] pstep_reg;

    // lfo and gain
    logic [PHASE_W-1:0]        phase_reg;
    logic signed [S17_W-1:0]   s17_reg;
    logic [DEPTH_W-1:0]        dclamp_reg;
    logic [1:0]                quad;
    logic [QTR_BITS-1:0]       qj;
    logic [QTR_BITS:0]         qidx;
    logic [GAIN_W-1:0]         sine_mag;
    logic signed [S17_W-1:0]   s17_val;
    logic signed [GAIN_W+1:0]  gain_sum;
    logic [GAIN_W-1:0]         gain_val;

    // history and filter
    logic [GAIN_W-1:0]         hist_mem [TAPS];
    logic [TAPS-1:0]           hist_vld_reg;
    logic [TAP_IDX_W-1:0]      pos_reg;
    logic [TAP_IDX_W-1:0]      pos_next;
    logic [TAP_IDX_W-1:0]      rd_idx_reg;
    logic [TAP_IDX_W-1:0]      k_reg;
    logic [GAIN_W-1:0]         rd_data_reg;
    logic                      rd_ok_reg;
    logic signed [COEF_W-1:0]  w_reg;
    logic                      p1_reg;
    logic                      p2_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [FG_W-1:0]    fg_reg;

    // multiplier and output
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_W-1:0]    mul_reg;
    logic signed [MUL_W-1:0]    mul_rnd;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic signed [SAMPLE_W-1:0] left_res_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic                       out_valid_reg;

    assign uc       = ucode(pc_reg);
    assign in_fire  = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || sample_out.ready;
    assign tap_last = k_reg == TAP_LAST;

    assign sample_in.ready      = uc.accept;
    assign cfg.ready            = 1'b1;
    assign sample_out.valid     = out_valid_reg;
    assign sample_out.left_out  = out_left_reg;
    assign sample_out.right_out = out_right_reg;

    always_comb
    begin
        case (uc.br)
            BR_NEXT:     pc_next = pc_reg + 1'b1;
            BR_JUMP:     pc_next = uc.target;
            BR_WAIT_IN:  pc_next = sample_in.valid ? pc_reg + 1'b1 : pc_reg;
            BR_LOOP:     pc_next = tap_last ? pc_reg + 1'b1 : uc.target;
            BR_WAIT_OUT: pc_next = out_free ? uc.target : pc_reg;
            default:     pc_next = ST_IDLE;
        endcase
    end

    // quarter-wave sine lookup on the top phase bits
    assign quad     = phase_reg[PHASE_W-1 -: 2];
    assign qj       = phase_reg[PHASE_W-3 -: QTR_BITS];
    assign qidx     = quad[0] ? (QTR_BITS + 1)'(QTR_N) - {1'b0, qj} : {1'b0, qj};
    assign sine_mag = qidx[QTR_BITS] ? SINE_PEAK : SINE_QTR[qidx[QTR_BITS-1:0]];
    assign s17_val  = quad[1] ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});

    // shared multiplier operands
    always_comb
    begin
        case (uc.mul_sel)
            MUL_GAIN:
            begin
                mul_a = MUL_A_W'(signed'({1'b0, dclamp_reg}));
                mul_b = MUL_B_W'(s17_reg);
            end
            MUL_TAP:
            begin
                mul_a = MUL_A_W'(w_reg);
                mul_b = rd_ok_reg ? MUL_B_W'({1'b0, rd_data_reg}) : '0;
            end
            MUL_LEFT:
            begin
                mul_a = fg_reg;
                mul_b = MUL_B_W'(left_reg);
            end
            MUL_RIGHT:
            begin
                mul_a = fg_reg;
                mul_b = MUL_B_W'(right_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_rnd = (mul_reg + MUL_HALF) >>> GAIN_FRAC;

    assign gain_sum = GAIN_ONE_S - signed'((GAIN_W + 2)'(dclamp_reg))
                      + (GAIN_W + 2)'(mul_rnd);

    always_comb
    begin
        if (gain_sum < 0)
        begin
            gain_val = '0;
        end
        else if (gain_sum > GAIN_ONE_S)
        begin
            gain_val = GAIN_ONE;
        end
        else
        begin
            gain_val = GAIN_W'(gain_sum);
        end
    end

    always_comb
    begin
        if (mul_rnd > SAT_MAX)
        begin
            sat_val = SAMPLE_W'(SAT_MAX);
        end
        else if (mul_rnd < SAT_MIN)
        begin
            sat_val = SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            sat_val = SAMPLE_W'(mul_rnd);
        end
    end

    assign pos_next = (pos_reg == TAP_LAST) ? '0 : pos_reg + 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            depth_reg     <= DEPTH_RESET;
            pstep_reg     <= PSTEP_RESET;
            phase_reg     <= '0;
            hist_vld_reg  <= '0;
            pos_reg       <= '0;
            rd_idx_reg    <= '0;
            k_reg         <= '0;
            rd_ok_reg     <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            p1_reg <= uc.tap_issue;
            p2_reg <= p1_reg;

            if (cfg.valid)
            begin
                case (cfg.addr)
                    REG_DEPTH:      depth_reg <= cfg.data[DEPTH_W-1:0];
                    REG_PHASE_STEP: pstep_reg <= cfg.data[PSTEP_W-1:0];
                    default:        depth_reg <= depth_reg;
                endcase
            end

            if (uc.lfo)
            begin
                phase_reg <= phase_reg + PHASE_W'(pstep_reg);
                k_reg     <= '0;
            end

            if (uc.hist_wr)
            begin
                hist_vld_reg[pos_next] <= 1'b1;
                pos_reg                <= pos_next;
                rd_idx_reg             <= pos_next;
            end

            if (uc.tap_issue)
            begin
                rd_ok_reg  <= hist_vld_reg[rd_idx_reg];
                rd_idx_reg <= (rd_idx_reg == '0) ? TAP_LAST : rd_idx_reg - 1'b1;
                k_reg      <= tap_last ? '0 : k_reg + 1'b1;
            end

            if (uc.out_ld && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sample_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (uc.hist_wr)
        begin
            hist_mem[pos_next] <= gain_val;
        end
        if (uc.tap_issue)
        begin
            rd_data_reg <= hist_mem[rd_idx_reg];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_reg  <= sample_in.left_in;
            right_reg <= sample_in.right_in;
        end
        if (uc.lfo)
        begin
            s17_reg    <= s17_val;
            dclamp_reg <= (depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg;
            acc_reg    <= '0;
        end
        else if (p2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(mul_reg);
        end
        if (uc.tap_issue)
        begin
            w_reg <= TAP_WEIGHTS[k_reg];
        end
        if (uc.mul_sel != MUL_NONE)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (uc.fg_ld)
        begin
            fg_reg <= FG_W'((acc_reg + ACC_HALF) >>> GAIN_FRAC);
        end
        if (uc.left_ld)
        begin
            left_res_reg <= sat_val;
        end
        if (uc.out_ld && out_free)
        begin
            out_left_reg  <= left_res_reg;
            out_right_reg <= sat_val;
        end
    end

    // an accepted item starts the lfo step next
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> pc_reg == ST_LFO)
        else $error("item accepted but sequencer did not start");

    // accumulate only inside the filter loop, its drain and the settle step
    a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
        p2_reg |-> (pc_reg == ST_TAP || pc_reg == ST_DRAIN || pc_reg == ST_SETTLE))
        else $error("tap product accumulated outside the filter loop");

    // a new result appears only from the output step
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_out.valid) |-> $past(pc_reg) == ST_OUT)
        else $error("output valid raised outside the output step");

endmodule

`default_nettype wire

FILE: dv/tremolo_gain_checker.sv
`timescale 1ns / 100ps

module tremolo_gain_checker (
    input  logic clk,
    input  logic rst_n,
    tsg_cfg_if   cfg,
    tsg_in_if    sample_in,
    tsg_out_if   sample_out,
    output int   mismatches,
    output int   frames_owed
);
    import tsg_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_t;

    logic [PHASE_W-1:0]       lfo_phase;
    logic [GAIN_W-1:0]        gain_hist [TAPS];
    logic signed [COEF_W-1:0] tap_w [TAPS];
    logic [DEPTH_W-1:0]       depth_reg;
    logic [PSTEP_W-1:0]       step_reg;
    stereo_t                  owed [$];
    stereo_t                  want;
    stereo_t                  got;

    // polynomial sine of a full-turn phase, q30
    function automatic longint lfo_sine(input logic [31:0] ph);
        int unsigned     divs [5] = '{110, 72, 42, 20, 6};
        longint unsigned g;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        g = ph[29:0];
        if (ph[30])
        begin
            g = Q30_ONE - g;
        end
        x  = (g * HALF_PI_Q30 + Q30_HALF) >> 30;
        x2 = (x * x + Q30_HALF) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 5; k++)
        begin
            t = Q30_ONE - (((x2 * t + Q30_HALF) >> 30) / divs[k]);
        end
        s = (x * t + Q30_HALF) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return ph[31] ? -longint'(s) : longint'(s);
    endfunction

    // windowed sinc tap, q1.17
    function automatic logic signed [COEF_W-1:0] smoothing_weight(input int i);
        int              mid;
        longint unsigned sinc;
        longint unsigned d;
        longint unsigned r;
        longint unsigned sm;
        longint unsigned mag;
        logic [31:0]     p;
        logic [31:0]     wq;
        longint          s;
        longint          w;
        longint          half;
        logic            neg;
        mid  = (TAPS - 1) / 2;
        neg  = 1'b0;
        half = Q30_HALF;
        if (i == mid)
        begin
            sinc = ((64'd2 * CUTOFF_HZ << 30) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
        end
        else
        begin
            d    = (i > mid) ? 64'(i - mid) : 64'(mid - i);
            r    = (64'(CUTOFF_HZ) * d) % SAMPLE_RATE_HZ;
            p    = 32'(((r << 32) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ);
            s    = lfo_sine(p);
            neg  = s < 0;
            sm   = neg ? -s : s;
            sinc = ((sm * INV_PI_Q30) / d + Q30_HALF) >> 30;
        end
        wq = 32'(((64'(i) << 32) + (TAPS - 1) / 2) / (TAPS - 1));
        w  = WIN_A_Q30 - ((WIN_B_Q30 * lfo_sine(wq + 32'h4000_0000) + half) >>> 30);
        if (w < 0)
        begin
            w = 0;
        end
        mag = (sinc * w + (64'd1 << 42)) >> 43;
        return neg ? -COEF_W'(mag) : COEF_W'(mag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
        if (v > 8388607)
        begin
            v = 8388607;
        end
        else if (v < -8388608)
        begin
            v = -8388608;
        end
        return SAMPLE_W'(v);
    endfunction

    // one sample: lfo gain, smoothing filter, scale both channels
    function automatic stereo_t tremolo_frame(input logic signed [SAMPLE_W-1:0] l, r);
        longint  s30;
        longint  s17;
        longint  dep;
        longint  gain;
        longint  acc;
        longint  fg;
        longint  wk;
        longint  hk;
        longint  l64;
        longint  r64;
        stereo_t res;
        s30 = lfo_sine(lfo_phase & ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1));
        s17 = (s30 < 0) ? -((-s30 + 4096) >>> 13) : ((s30 + 4096) >>> 13);
        dep = (depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg;
        gain = GAIN_ONE;
        gain = gain - dep + ((dep * s17 + 65536) >>> 17);
        if (gain < 0)
        begin
            gain = 0;
        end
        if (gain > GAIN_ONE)
        begin
            gain = GAIN_ONE;
        end
        lfo_phase = lfo_phase + step_reg;
        for (int k = TAPS - 1; k > 0; k--)
        begin
            gain_hist[k] = gain_hist[k-1];
        end
        gain_hist[0] = GAIN_W'(gain);
        acc = 0;
        for (int k = 0; k < TAPS; k++)
        begin
            wk  = tap_w[k];
            hk  = gain_hist[k];
            acc = acc + wk * hk;
        end
        fg  = (acc + 65536) >>> 17;
        l64 = l;
        r64 = r;
        res.left  = clip_sample((l64 * fg + 65536) >>> 17);
        res.right = clip_sample((r64 * fg + 65536) >>> 17);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic signed [SAMPLE_W-1:0] exp_v,
                                 input logic signed [SAMPLE_W-1:0] got_v);
        $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    initial
    begin
        foreach (tap_w[i])
        begin
            tap_w[i] = smoothing_weight(i);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_phase = '0;
            foreach (gain_hist[i])
            begin
                gain_hist[i] = '0;
            end
            depth_reg = DEPTH_RESET;
            step_reg  = PSTEP_RESET;
            owed.delete();
            frames_owed <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.addr == REG_DEPTH)
                begin
                    depth_reg = cfg.data[DEPTH_W-1:0];
                end
                else if (cfg.addr == REG_PHASE_STEP)
                begin
                    step_reg = cfg.data[PSTEP_W-1:0];
                end
            end
            if (sample_in.valid && sample_in.ready)
            begin
                owed.push_back(tremolo_frame(sample_in.left_in, sample_in.right_in));
            end
            if (sample_out.valid && sample_out.ready)
            begin
                got.left  = sample_out.left_out;
                got.right = sample_out.right_out;
                if (owed.size() == 0)
                begin
                    flag_mismatch("result with no item pending, left", '0, got.left);
                end
                else
                begin
                    want = owed.pop_front();
                    if (got.left !== want.left)
                    begin
                        flag_mismatch("left_out", want.left, got.left);
                    end
                    if (got.right !== want.right)
                    begin
                        flag_mismatch("right_out", want.right, got.right);
                    end
                end
            end
            frames_owed <= owed.size();
        end
    end

endmodule

FILE: dv/tremolo_sine_lfo_smoothed_gain_unit_tb.sv
`timescale 1ns / 100ps

module tremolo_sine_lfo_smoothed_gain_unit_tb;

    import tsg_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = CFG_ADDR_W'(3);

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

    localparam logic [CFG_DATA_W-1:0] STEP_TOP  = 20'hFFFFF;
    localparam logic [CFG_DATA_W-1:0] STEP_RATE = 20'd894785;

    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE       = 150;
    localparam int TOP_SAMPLES  = 180;

    logic clk = 1'b0;
    logic rst_n;

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_id;
    int mismatches;
    int frames_owed;

    tsg_cfg_if cfg_ch ();
    tsg_in_if  in_ch ();
    tsg_out_if out_ch ();

    tremolo_sine_lfo_smoothed_gain_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .sample_in  (in_ch),
        .sample_out (out_ch)
    );

    tremolo_gain_checker gain_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .sample_in   (in_ch),
        .sample_out  (out_ch),
        .mismatches  (mismatches),
        .frames_owed (frames_owed)
    );

    always #5 clk = ~clk;

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l, r);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // stop offering and wait for every owed result
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (frames_owed != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] dep, step);
        settle_block();
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_DEPTH, dep);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_W'($signed($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_depth();
        case ($urandom_range(3))
            0:       return CFG_DATA_W'($urandom);
            1:       return CFG_DATA_W'(DEPTH_FULL);
            default: return CFG_DATA_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        if ($urandom_range(2) == 0)
        begin
            return CFG_DATA_W'($urandom);
        end
        return CFG_DATA_W'($urandom_range(894785));
    endfunction

    task automatic run_random(input int n);
        repeat (n)
        begin
            send_frame(rand_sample(), rand_sample());
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_id)
            begin
                hold_seen = hold_id;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [SAMPLE_W-1:0] corner_l [7];
        logic signed [SAMPLE_W-1:0] corner_r [7];
        corner_l = '{S_MAX, S_MIN, 24'sd0, -24'sd1, 24'sd1, S_MAX, S_MIN};
        corner_r = '{S_MIN, S_MAX, 24'sd0, 24'sd1, -24'sd1, S_MAX, S_MIN};

        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.addr    = '0;
        cfg_ch.data    = '0;
        snd_idle_pct   = 23;
        rcv_idle_pct   = 71;
        hold_id        = 0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        run_random(4);

        // full depth, fastest lfo
        load_settings(CFG_DATA_W'(DEPTH_FULL), STEP_TOP);
        foreach (corner_l[i])
        begin
            send_frame(corner_l[i], corner_r[i]);
        end

        // no depth, frozen lfo
        load_settings('0, '0);
        run_random(4);

        // depth beyond full, upper data bits set
        load_settings(20'hFFFFF, STEP_RATE);
        foreach (corner_l[i])
        begin
            send_frame(corner_l[i], corner_r[i]);
        end

        for (int seg = 0; seg < 3; seg++)
        begin
            load_settings(pick_depth(), pick_step());
            if (seg == 1)
            begin
                hold_id <= hold_id + 1;
            end
            run_random(50);
        end

        snd_idle_pct = 71;
        rcv_idle_pct <= 23;
        for (int seg = 0; seg < 3; seg++)
        begin
            load_settings(pick_depth(), pick_step());
            if (seg == 2)
            begin
                hold_id <= hold_id + 1;
            end
            run_random(50);
        end

        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        for (int seg = 0; seg < 2; seg++)
        begin
            load_settings(pick_depth(), pick_step());
            run_random(100);
        end

        // closing run at the top step
        load_settings(pick_depth(), STEP_TOP);
        run_random(TOP_SAMPLES);

        settle_block();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tsg_pkg.sv
rtl/tsg_ifs.sv
rtl/tremolo_sine_lfo_smoothed_gain_unit.sv
dv/tremolo_gain_checker.sv
dv/tremolo_sine_lfo_smoothed_gain_unit_tb.sv
